/* sv/arc_endpoint_clipper_unit_macros.svh */
// assertion macros for the clipper
`ifndef ARC_ENDPOINT_CLIPPER_UNIT_MACROS_SVH
`define ARC_ENDPOINT_CLIPPER_UNIT_MACROS_SVH
`ifndef SYNTH
`define AEC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aec assertion failed");
`define AEC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aec assertion failed");
`else
`define AEC_ASSERT_NOW(lbl, ante, cons)
`define AEC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* sv/aec_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package aec_pkg;
  localparam int RADIUS_BITS = 12;
  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 12'd16;
  localparam int SQ_BITS = 2 * RADIUS_BITS;
  localparam int ROOT_BITS = 12;
  localparam int RADICAND_BITS = 2 * ROOT_BITS;
  localparam int ADDR_BITS = 3;
  localparam logic REG_RADIUS = 1'b0;
  localparam logic MODE_CIRCLE = 1'b0;
  localparam logic MODE_BOX = 1'b1;

  typedef struct packed {
    logic mode;
    logic same;
    logic vx_nz;
    logic vy_nz;
    logic neg_vx;
    logic neg_vy;
    logic neg_ox;
    logic neg_oy;
  } aec_flags_t;

  localparam int FLAG_BITS = $bits(aec_flags_t);
endpackage
`default_nettype wire

/* sv/aec_seg_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface aec_seg_if #(parameter int C = 16);
  logic valid;
  logic ready;
  logic mode;
  logic signed [C-1:0] start_x;
  logic signed [C-1:0] start_y;
  logic signed [C-1:0] end_x;
  logic signed [C-1:0] end_y;
  logic signed [C-1:0] rect_left;
  logic signed [C-1:0] rect_top;
  logic signed [C-1:0] rect_right;
  logic signed [C-1:0] rect_bottom;
  modport source(output valid, mode, start_x, start_y, end_x, end_y, rect_left, rect_top,
                 rect_right, rect_bottom, input ready);
  modport sink(input valid, mode, start_x, start_y, end_x, end_y, rect_left, rect_top,
               rect_right, rect_bottom, output ready);
endinterface
`default_nettype wire

/* sv/aec_pt_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface aec_pt_if #(parameter int C = 16);
  logic valid;
  logic ready;
  logic signed [C-1:0] out_x;
  logic signed [C-1:0] out_y;
  modport source(output valid, out_x, out_y, input ready);
  modport sink(input valid, out_x, out_y, output ready);
endinterface
`default_nettype wire

/* sv/aec_prep.sv */
`timescale 1ns / 1ps
`default_nettype none
module aec_prep
  import aec_pkg::*;
#(
  parameter int C = 16,
  localparam int NW = 2 * C + SQ_BITS,
  localparam int DW = 2 * C + 1,
  localparam int CW = 8 * C,
  localparam int SW = FLAG_BITS + CW
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [RADIUS_BITS-1:0] radius,
  aec_seg_if.sink                seg,
  output logic                   valid,
  input  logic                   ready,
  output logic [NW-1:0]          num0,
  output logic [NW-1:0]          num1,
  output logic [DW-1:0]          den0,
  output logic [DW-1:0]          den1,
  output logic [SW-1:0]          side
);
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic s1_vld, s2_vld, s3_vld, s4_vld;

  // stage 1: differences and target edges
  logic                s1_mode;
  logic signed [C-1:0] s1_sx, s1_sy, s1_ex, s1_ey, s1_left, s1_right, s1_tx, s1_ty;
  logic signed [C:0]   s1_vx, s1_vy;
  // stage 2: magnitudes and flags
  aec_flags_t          s2_fl;
  logic [CW-1:0]       s2_co;
  logic [C-1:0]        s2_mvx, s2_mvy, s2_mbx, s2_mby;
  // stage 3: products
  aec_flags_t          s3_fl;
  logic [CW-1:0]       s3_co;
  logic [C-1:0]        s3_mvx, s3_mvy;
  logic [2*C-1:0]      s3_sqx, s3_sqy, s3_px, s3_py;
  logic [SQ_BITS-1:0]  s3_rsq;
  // stage 4: sum of squares and split radius products
  aec_flags_t          s4_fl;
  logic [CW-1:0]       s4_co;
  logic [C-1:0]        s4_mvx, s4_mvy;
  logic [2*C-1:0]      s4_px, s4_py;
  logic [DW-1:0]       s4_s;
  logic [SQ_BITS+C-1:0] s4_rxl, s4_rxh, s4_ryl, s4_ryh;

  logic [C:0] s1_nvx, s1_nvy, s1_bx, s1_by, s1_nbx, s1_nby;

  assign rdy5 = ~valid | ready;
  assign rdy4 = ~s4_vld | rdy5;
  assign rdy3 = ~s3_vld | rdy4;
  assign rdy2 = ~s2_vld | rdy3;
  assign rdy1 = ~s1_vld | rdy2;
  assign seg.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      valid  <= 1'b0;
    end else begin
      if (rdy1) s1_vld <= seg.valid;
      if (rdy2) s2_vld <= s1_vld;
      if (rdy3) s3_vld <= s2_vld;
      if (rdy4) s4_vld <= s3_vld;
      if (rdy5) valid  <= s4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_mode  <= seg.mode;
      s1_sx    <= seg.start_x;
      s1_sy    <= seg.start_y;
      s1_ex    <= seg.end_x;
      s1_ey    <= seg.end_y;
      s1_left  <= seg.rect_left;
      s1_right <= seg.rect_right;
      s1_vx    <= {seg.start_x[C-1], seg.start_x} - {seg.end_x[C-1], seg.end_x};
      s1_vy    <= {seg.start_y[C-1], seg.start_y} - {seg.end_y[C-1], seg.end_y};
      s1_ty    <= (seg.start_y > seg.end_y) ? seg.rect_bottom : seg.rect_top;
      s1_tx    <= (seg.start_x > seg.end_x) ? seg.rect_right : seg.rect_left;
    end
  end

  assign s1_bx  = {s1_ty[C-1], s1_ty} - {s1_sy[C-1], s1_sy};
  assign s1_by  = {s1_tx[C-1], s1_tx} - {s1_sx[C-1], s1_sx};
  assign s1_nvx = -s1_vx;
  assign s1_nvy = -s1_vy;
  assign s1_nbx = -s1_bx;
  assign s1_nby = -s1_by;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_mvx <= s1_vx[C] ? s1_nvx[C-1:0] : s1_vx[C-1:0];
      s2_mvy <= s1_vy[C] ? s1_nvy[C-1:0] : s1_vy[C-1:0];
      s2_mbx <= s1_bx[C] ? s1_nbx[C-1:0] : s1_bx[C-1:0];
      s2_mby <= s1_by[C] ? s1_nby[C-1:0] : s1_by[C-1:0];
      s2_fl.mode   <= s1_mode;
      s2_fl.same   <= (s1_vx == '0) && (s1_vy == '0);
      s2_fl.vx_nz  <= s1_vx != '0;
      s2_fl.vy_nz  <= s1_vy != '0;
      s2_fl.neg_vx <= s1_vx[C];
      s2_fl.neg_vy <= s1_vy[C];
      s2_fl.neg_ox <= s1_vx[C] ^ s1_bx[C] ^ s1_vy[C];
      s2_fl.neg_oy <= s1_vy[C] ^ s1_by[C] ^ s1_vx[C];
      s2_co <= {s1_sx, s1_sy, s1_ex, s1_ey, s1_left, s1_right, s1_tx, s1_ty};
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_sqx <= s2_mvx * s2_mvx;
      s3_sqy <= s2_mvy * s2_mvy;
      s3_px  <= s2_mvx * s2_mbx;
      s3_py  <= s2_mvy * s2_mby;
      s3_rsq <= radius * radius;
      s3_mvx <= s2_mvx;
      s3_mvy <= s2_mvy;
      s3_fl  <= s2_fl;
      s3_co  <= s2_co;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_s   <= {1'b0, s3_sqx} + {1'b0, s3_sqy};
      s4_rxl <= s3_rsq * s3_sqx[C-1:0];
      s4_rxh <= s3_rsq * s3_sqx[2*C-1:C];
      s4_ryl <= s3_rsq * s3_sqy[C-1:0];
      s4_ryh <= s3_rsq * s3_sqy[2*C-1:C];
      s4_px  <= s3_px;
      s4_py  <= s3_py;
      s4_mvx <= s3_mvx;
      s4_mvy <= s3_mvy;
      s4_fl  <= s3_fl;
      s4_co  <= s3_co;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      if (s4_fl.mode == MODE_BOX) begin
        num0 <= NW'(s4_px);
        num1 <= NW'(s4_py);
        den0 <= DW'(s4_mvy);
        den1 <= DW'(s4_mvx);
      end else begin
        num0 <= {s4_rxh, {C{1'b0}}} + NW'(s4_rxl);
        num1 <= {s4_ryh, {C{1'b0}}} + NW'(s4_ryl);
        den0 <= s4_s;
        den1 <= s4_s;
      end
      side <= {s4_fl, s4_co};
    end
  end
endmodule
`default_nettype wire

/* sv/aec_div.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "arc_endpoint_clipper_unit_macros.svh"
module aec_div
  import aec_pkg::*;
#(
  parameter int C = 16,
  localparam int NW = 2 * C + SQ_BITS,
  localparam int DW = 2 * C + 1,
  localparam int SW = FLAG_BITS + 8 * C
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [NW-1:0] num0,
  input  logic [NW-1:0] num1,
  input  logic [DW-1:0] den0,
  input  logic [DW-1:0] den1,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [NW-1:0] quot0,
  output logic [NW-1:0] quot1,
  output logic [SW-1:0] out_side
);
  // one quotient bit per stage, restoring
  logic          vld [1:NW];
  logic          rdy [NW];
  logic [NW-1:0] n0 [1:NW];
  logic [NW-1:0] n1 [1:NW];
  logic [DW-1:0] d0 [1:NW];
  logic [DW-1:0] d1 [1:NW];
  logic [DW-1:0] r0 [1:NW];
  logic [DW-1:0] r1 [1:NW];
  logic [SW-1:0] sd [1:NW];

  assign rdy[NW-1] = ~vld[NW] | out_ready;
  assign in_ready  = rdy[0];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic          iv;
    logic [NW-1:0] in0, in1;
    logic [DW-1:0] id0, id1, ir0, ir1;
    logic [SW-1:0] isd;
    logic [DW:0]   t0, t1, f0, f1;
    logic          g0, g1;

    if (k == 0) begin : g_first
      assign iv  = in_valid;
      assign in0 = num0;
      assign in1 = num1;
      assign id0 = den0;
      assign id1 = den1;
      assign ir0 = '0;
      assign ir1 = '0;
      assign isd = in_side;
    end else begin : g_next
      assign iv  = vld[k];
      assign in0 = n0[k];
      assign in1 = n1[k];
      assign id0 = d0[k];
      assign id1 = d1[k];
      assign ir0 = r0[k];
      assign ir1 = r1[k];
      assign isd = sd[k];
    end

    if (k < NW - 1) begin : g_rdy
      assign rdy[k] = ~vld[k+1] | rdy[k+1];
    end

    assign t0 = {ir0, in0[NW-1]};
    assign t1 = {ir1, in1[NW-1]};
    assign g0 = t0 >= {1'b0, id0};
    assign g1 = t1 >= {1'b0, id1};
    assign f0 = t0 - {1'b0, id0};
    assign f1 = t1 - {1'b0, id1};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k+1] <= iv;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        n0[k+1] <= {in0[NW-2:0], g0};
        n1[k+1] <= {in1[NW-2:0], g1};
        r0[k+1] <= g0 ? f0[DW-1:0] : t0[DW-1:0];
        r1[k+1] <= g1 ? f1[DW-1:0] : t1[DW-1:0];
        d0[k+1] <= id0;
        d1[k+1] <= id1;
        sd[k+1] <= isd;
      end
    end
  end

  assign out_valid = vld[NW];
  assign quot0     = n0[NW];
  assign quot1     = n1[NW];
  assign out_side  = sd[NW];

  `AEC_ASSERT_NOW(a_rem0_below, vld[NW] && d0[NW] != '0, r0[NW] < d0[NW])
  `AEC_ASSERT_NOW(a_rem1_below, vld[NW] && d1[NW] != '0, r1[NW] < d1[NW])
endmodule
`default_nettype wire

/* sv/aec_sqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "arc_endpoint_clipper_unit_macros.svh"
module aec_sqrt
  import aec_pkg::*;
#(
  parameter int C = 16,
  localparam int NW = 2 * C + SQ_BITS,
  localparam int SW = FLAG_BITS + 8 * C
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [NW-1:0]        quot0,
  input  logic [NW-1:0]        quot1,
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ROOT_BITS-1:0] root0,
  output logic [ROOT_BITS-1:0] root1,
  output logic [NW-1:0]        out_quot0,
  output logic [NW-1:0]        out_quot1,
  output logic [SW-1:0]        out_side
);
  // one root bit per stage
  logic                 vld [1:ROOT_BITS];
  logic                 rdy [ROOT_BITS];
  logic [ROOT_BITS-1:0] q0 [1:ROOT_BITS];
  logic [ROOT_BITS-1:0] q1 [1:ROOT_BITS];
  logic [NW-1:0]        x0 [1:ROOT_BITS];
  logic [NW-1:0]        x1 [1:ROOT_BITS];
  logic [SW-1:0]        sd [1:ROOT_BITS];

  assign rdy[ROOT_BITS-1] = ~vld[ROOT_BITS] | out_ready;
  assign in_ready         = rdy[0];

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
    logic                     iv;
    logic [ROOT_BITS-1:0]     iq0, iq1, t0, t1;
    logic [NW-1:0]            ix0, ix1;
    logic [SW-1:0]            isd;
    logic [RADICAND_BITS-1:0] sq0, sq1;

    if (k == 0) begin : g_first
      assign iv  = in_valid;
      assign iq0 = '0;
      assign iq1 = '0;
      assign ix0 = quot0;
      assign ix1 = quot1;
      assign isd = in_side;
    end else begin : g_next
      assign iv  = vld[k];
      assign iq0 = q0[k];
      assign iq1 = q1[k];
      assign ix0 = x0[k];
      assign ix1 = x1[k];
      assign isd = sd[k];
    end

    if (k < ROOT_BITS - 1) begin : g_rdy
      assign rdy[k] = ~vld[k+1] | rdy[k+1];
    end

    assign t0  = iq0 | (ROOT_BITS'(1) << (ROOT_BITS - 1 - k));
    assign t1  = iq1 | (ROOT_BITS'(1) << (ROOT_BITS - 1 - k));
    assign sq0 = t0 * t0;
    assign sq1 = t1 * t1;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k+1] <= iv;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        q0[k+1] <= (sq0 <= ix0[RADICAND_BITS-1:0]) ? t0 : iq0;
        q1[k+1] <= (sq1 <= ix1[RADICAND_BITS-1:0]) ? t1 : iq1;
        x0[k+1] <= ix0;
        x1[k+1] <= ix1;
        sd[k+1] <= isd;
      end
    end
  end

  assign out_valid = vld[ROOT_BITS];
  assign root0     = q0[ROOT_BITS];
  assign root1     = q1[ROOT_BITS];
  assign out_quot0 = x0[ROOT_BITS];
  assign out_quot1 = x1[ROOT_BITS];
  assign out_side  = sd[ROOT_BITS];

  `AEC_ASSERT_NOW(a_root_fits, vld[ROOT_BITS], (RADICAND_BITS'(root0) * RADICAND_BITS'(root0)) <= x0[ROOT_BITS][RADICAND_BITS-1:0])
endmodule
`default_nettype wire

/* sv/aec_finish.sv */
`timescale 1ns / 1ps
`default_nettype none
module aec_finish
  import aec_pkg::*;
#(
  parameter int C = 16,
  localparam int NW = 2 * C + SQ_BITS,
  localparam int SW = FLAG_BITS + 8 * C,
  localparam int OW = C + ROOT_BITS,
  localparam int FW = 2 * C + 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ROOT_BITS-1:0] root0,
  input  logic [ROOT_BITS-1:0] root1,
  input  logic [NW-1:0]        quot0,
  input  logic [NW-1:0]        quot1,
  input  logic [SW-1:0]        side,
  aec_pt_if.source             pt
);
  aec_flags_t          fl;
  logic signed [C-1:0] sx, sy, ex, ey, left, right, tx, ty;
  logic [OW-1:0]       ox_c, oy_c, cxs, cys;
  logic signed [FW-1:0] mx, my, fx, fy;
  logic                outside;

  logic       f1_vld, rdy1, rdy2;
  aec_flags_t f1_fl;
  logic [C-1:0] f1_cx, f1_cy, f1_bx, f1_by, f1_ex, f1_ey, f1_tx, f1_ty;
  logic       f1_out;
  logic [C-1:0] ox_next, oy_next, out_x, out_y;
  logic       valid;

  assign fl    = side[SW-1 -: FLAG_BITS];
  assign sx    = side[8*C-1 -: C];
  assign sy    = side[7*C-1 -: C];
  assign ex    = side[6*C-1 -: C];
  assign ey    = side[5*C-1 -: C];
  assign left  = side[4*C-1 -: C];
  assign right = side[3*C-1 -: C];
  assign tx    = side[2*C-1 -: C];
  assign ty    = side[C-1:0];

  // circle offsets
  assign ox_c = fl.neg_vx ? -OW'(root0) : OW'(root0);
  assign oy_c = fl.neg_vy ? -OW'(root1) : OW'(root1);
  assign cxs  = OW'(ex) + ox_c;
  assign cys  = OW'(ey) + oy_c;

  // box edge crossings at full precision
  assign mx      = FW'(quot0[2*C-1:0]);
  assign my      = FW'(quot1[2*C-1:0]);
  assign fx      = FW'(sx) + (fl.neg_ox ? -mx : mx);
  assign fy      = FW'(sy) + (fl.neg_oy ? -my : my);
  assign outside = (fx < FW'(left)) || (fx > FW'(right));

  assign rdy2     = ~valid | pt.ready;
  assign rdy1     = ~f1_vld | rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_vld <= 1'b0;
      valid  <= 1'b0;
    end else begin
      if (rdy1) f1_vld <= in_valid;
      if (rdy2) valid  <= f1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      f1_fl  <= fl;
      f1_cx  <= cxs[C-1:0];
      f1_cy  <= cys[C-1:0];
      f1_bx  <= fx[C-1:0];
      f1_by  <= fy[C-1:0];
      f1_out <= outside;
      f1_ex  <= ex;
      f1_ey  <= ey;
      f1_tx  <= tx;
      f1_ty  <= ty;
    end
  end

  always_comb begin
    ox_next = f1_ex;
    oy_next = f1_ey;
    if (!f1_fl.same) begin
      if (f1_fl.mode == MODE_CIRCLE) begin
        ox_next = f1_cx;
        oy_next = f1_cy;
      end else begin
        if (f1_fl.vy_nz) begin
          ox_next = f1_bx;
          oy_next = f1_ty;
        end
        if ((!f1_fl.vy_nz || f1_out) && f1_fl.vx_nz) begin
          ox_next = f1_tx;
          oy_next = f1_by;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      out_x <= ox_next;
      out_y <= oy_next;
    end
  end

  assign pt.valid = valid;
  assign pt.out_x = out_x;
  assign pt.out_y = out_y;
endmodule
`default_nettype wire

/* sv/arc_endpoint_clipper_unit.sv */
// throughput: one request per cycle unless the output stalls; the divider retires one
// quotient bit per stage and the root unit one root bit per stage; a stall holds only
// the full stages behind it while empty stages keep moving
// reset: clears all pipeline valid bits and sets radius to 16
`timescale 1ns / 1ps
`default_nettype none
`include "arc_endpoint_clipper_unit_macros.svh"
module arc_endpoint_clipper_unit
  import aec_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  aec_seg_if.sink              seg,
  aec_pt_if.source             pt
);
  localparam int NW = 2 * COORD_BITS + SQ_BITS;
  localparam int DW = 2 * COORD_BITS + 1;
  localparam int SW = FLAG_BITS + 8 * COORD_BITS;

  logic [RADIUS_BITS-1:0] radius;
  logic                   cfg_wr;

  logic          p_valid, p_ready;
  logic [NW-1:0] p_num0, p_num1;
  logic [DW-1:0] p_den0, p_den1;
  logic [SW-1:0] p_side;

  logic          d_valid, d_ready;
  logic [NW-1:0] d_quot0, d_quot1;
  logic [SW-1:0] d_side;

  logic                 r_valid, r_ready;
  logic [ROOT_BITS-1:0] r_root0, r_root1;
  logic [NW-1:0]        r_quot0, r_quot1;
  logic [SW-1:0]        r_side;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[ADDR_BITS-1] == REG_RADIUS);
  assign prdata = (paddr[ADDR_BITS-1] == REG_RADIUS) ? 32'(radius) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg_wr) begin
      radius <= pwdata[RADIUS_BITS-1:0];
    end
  end

  aec_prep #(.C(COORD_BITS)) u_prep (
    .clk    (clk),
    .rst    (rst),
    .radius (radius),
    .seg    (seg),
    .valid  (p_valid),
    .ready  (p_ready),
    .num0   (p_num0),
    .num1   (p_num1),
    .den0   (p_den0),
    .den1   (p_den1),
    .side   (p_side)
  );

  aec_div #(.C(COORD_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p_valid),
    .in_ready  (p_ready),
    .num0      (p_num0),
    .num1      (p_num1),
    .den0      (p_den0),
    .den1      (p_den1),
    .in_side   (p_side),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .quot0     (d_quot0),
    .quot1     (d_quot1),
    .out_side  (d_side)
  );

  aec_sqrt #(.C(COORD_BITS)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .quot0     (d_quot0),
    .quot1     (d_quot1),
    .in_side   (d_side),
    .out_valid (r_valid),
    .out_ready (r_ready),
    .root0     (r_root0),
    .root1     (r_root1),
    .out_quot0 (r_quot0),
    .out_quot1 (r_quot1),
    .out_side  (r_side)
  );

  aec_finish #(.C(COORD_BITS)) u_finish (
    .clk      (clk),
    .rst      (rst),
    .in_valid (r_valid),
    .in_ready (r_ready),
    .root0    (r_root0),
    .root1    (r_root1),
    .quot0    (r_quot0),
    .quot1    (r_quot1),
    .side     (r_side),
    .pt       (pt)
  );

  `AEC_ASSERT_NEXT(a_cfg_write, cfg_wr, radius == $past(pwdata[RADIUS_BITS-1:0]))
endmodule
`default_nettype wire

/* bench/arc_endpoint_clipper_unit_tb.sv */
`timescale 1ns / 1ps
module arc_endpoint_clipper_unit_tb;
  import aec_pkg::*;

  localparam int C = 16;
  localparam int LATENCY = 2 * C + 43;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic mode;
    logic signed [C-1:0] sx, sy, ex, ey, left, top, right, bottom;
  } seg_t;

  typedef struct {
    logic signed [C-1:0] x, y;
  } pt_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int errors = 0;
  int idle_cycles = 0;
  bit no_idle = 1'b0;
  bit hold_off = 1'b0;
  logic [RADIUS_BITS-1:0] radius = RADIUS_RESET;

  aec_seg_if #(C) seg ();
  aec_pt_if #(C) pt ();

  arc_endpoint_clipper_unit #(.COORD_BITS(C)) i_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .seg(seg.sink), .pt(pt.source)
  );

  always #2 clk = ~clk;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // trunc magnitude of a*b/d with sign, added to base as the full-precision position
  function automatic longint edge_hit(longint base, longint a, longint b, longint d,
                                      output longint full);
    longint m;
    bit neg;
    m = ((a < 0 ? -a : a) * (b < 0 ? -b : b)) / (d < 0 ? -d : d);
    neg = (((a < 0) != (b < 0)) != (d < 0)) && m != 0;
    full = neg ? base - m : base + m;
    return full;
  endfunction

  function automatic longint radial_part(longint v, longint s, longint r);
    logic [127:0] rhs, lhs;
    longint q, t, av;
    av = v < 0 ? -v : v;
    rhs = 128'(av) * 128'(av) * 128'(r) * 128'(r);
    q = 0;
    for (int b = 11; b >= 0; b--) begin
      t = q | (longint'(1) << b);
      lhs = 128'(s) * 128'(t) * 128'(t);
      if (lhs <= rhs) q = t;
    end
    return v < 0 ? -q : q;
  endfunction

  function automatic pt_t clip_endpoint(seg_t s, logic [RADIUS_BITS-1:0] r);
    pt_t p;
    longint vx, vy, ox, oy, fx, tx, ty, dummy, sq;
    bit outside;
    vx = longint'(s.sx) - longint'(s.ex);
    vy = longint'(s.sy) - longint'(s.ey);
    ox = s.ex;
    oy = s.ey;
    if (vx != 0 || vy != 0) begin
      if (s.mode == MODE_CIRCLE) begin
        sq = vx * vx + vy * vy;
        ox = s.ex + radial_part(vx, sq, r);
        oy = s.ey + radial_part(vy, sq, r);
      end else begin
        outside = 1'b1;
        if (vy != 0) begin
          ty = s.sy > s.ey ? longint'(s.bottom) : longint'(s.top);
          fx = edge_hit(s.sx, vx, ty - s.sy, vy, dummy);
          ox = fx;
          oy = ty;
          outside = fx < s.left || fx > s.right;
        end
        if (outside && vx != 0) begin
          tx = s.sx > s.ex ? longint'(s.right) : longint'(s.left);
          oy = edge_hit(s.sy, vy, tx - s.sx, vx, dummy);
          ox = tx;
        end
      end
    end
    p.x = ox[C-1:0];
    p.y = oy[C-1:0];
    return p;
  endfunction

  class clip_scoreboard;
    pt_t pending[$];
    function void note_request(seg_t s, logic [RADIUS_BITS-1:0] r);
      pending.push_back(clip_endpoint(s, r));
    endfunction
    task check_point(pt_t got);
      pt_t want;
      if (pending.size() == 0) begin
        report("unexpected point x", got.x, 0);
        return;
      end
      want = pending.pop_front();
      if (got.x !== want.x) report("out_x", got.x, want.x);
      if (got.y !== want.y) report("out_y", got.y, want.y);
    endtask
  endclass

  clip_scoreboard sb = new();

  initial begin
    seg.valid = 1'b0;
    seg.mode = 1'b0;
    {seg.start_x, seg.start_y, seg.end_x, seg.end_y} = '0;
    {seg.rect_left, seg.rect_top, seg.rect_right, seg.rect_bottom} = '0;
    pt.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (seg.valid && seg.ready) idle_cycles <= 0;
      else if (pt.valid && pt.ready) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
        $display("[arc_endpoint_clipper_unit] ERROR");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pt.valid && pt.ready) sb.check_point('{x: pt.out_x, y: pt.out_y});
    if (rst) pt.ready <= 1'b0;
    else pt.ready <= !hold_off && (no_idle || $urandom_range(99) >= 7);
  end

  task automatic write_radius(input logic [RADIUS_BITS-1:0] r);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ADDR_BITS'(REG_RADIUS) * 4;
    pwdata <= 32'(r);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    radius = r;
  endtask

  task automatic send_seg(input seg_t s);
    if (!no_idle) begin
      while ($urandom_range(99) < 7) begin
        seg.valid <= 1'b0;
        @(posedge clk);
      end
    end
    seg.valid <= 1'b1;
    seg.mode <= s.mode;
    seg.start_x <= s.sx;
    seg.start_y <= s.sy;
    seg.end_x <= s.ex;
    seg.end_y <= s.ey;
    seg.rect_left <= s.left;
    seg.rect_top <= s.top;
    seg.rect_right <= s.right;
    seg.rect_bottom <= s.bottom;
    do @(posedge clk); while (!seg.ready);
    sb.note_request(s, radius);
  endtask

  task automatic drain();
    seg.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic signed [C-1:0] rand_coord();
    case ($urandom_range(3))
      0: return C'($urandom);
      1: return C'($signed($urandom_range(400)) - 200);
      2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return C'($signed($urandom_range(8000)) - 4000);
    endcase
  endfunction

  function automatic seg_t rand_seg();
    seg_t s;
    logic signed [C-1:0] a, b;
    s.mode = $urandom_range(1);
    s.ex = rand_coord();
    s.ey = rand_coord();
    case ($urandom_range(9))
      0: begin s.sx = s.ex; s.sy = s.ey; end
      1: begin s.sx = rand_coord(); s.sy = s.ey; end
      2: begin s.sx = s.ex; s.sy = rand_coord(); end
      default: begin s.sx = rand_coord(); s.sy = rand_coord(); end
    endcase
    if ($urandom_range(9) < 8) begin
      // rectangle around the end point most of the time
      a = C'($urandom_range(3000));
      b = C'($urandom_range(3000));
      s.left = s.ex - a;
      s.right = s.ex + C'($urandom_range(3000));
      s.top = s.ey - b;
      s.bottom = s.ey + C'($urandom_range(3000));
    end else begin
      s.left = rand_coord();
      s.right = rand_coord();
      s.top = rand_coord();
      s.bottom = rand_coord();
    end
    return s;
  endfunction

  function automatic seg_t mk(logic m, int sx, int sy, int ex, int ey,
                              int l, int t, int r, int b);
    seg_t s;
    s.mode = m;
    s.sx = C'(sx); s.sy = C'(sy); s.ex = C'(ex); s.ey = C'(ey);
    s.left = C'(l); s.top = C'(t); s.right = C'(r); s.bottom = C'(b);
    return s;
  endfunction

  initial begin
    logic [RADIUS_BITS-1:0] radii[4] = '{12'd0, 12'd4095, 12'd1, 12'd100};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, default radius
    send_seg(mk(MODE_CIRCLE, 5, 5, 5, 5, 0, 0, 0, 0));
    send_seg(mk(MODE_BOX, -7, 9, -7, 9, -10, -10, 10, 10));
    send_seg(mk(MODE_CIRCLE, 100, 0, 0, 0, 0, 0, 0, 0));
    send_seg(mk(MODE_CIRCLE, 3, 4, 0, 0, 0, 0, 0, 0));
    send_seg(mk(MODE_CIRCLE, 32767, 32767, -32768, -32768, 0, 0, 0, 0));
    send_seg(mk(MODE_CIRCLE, -32768, 32767, 32767, -32768, 0, 0, 0, 0));
    send_seg(mk(MODE_BOX, -100, 0, 0, 0, -10, -10, 10, 10));
    send_seg(mk(MODE_BOX, 100, 5, 0, 5, -10, -10, 10, 10));
    send_seg(mk(MODE_BOX, 0, 100, 0, 0, -10, -10, 10, 10));
    send_seg(mk(MODE_BOX, 50, -100, 0, 0, 20, -10, 40, 10));
    send_seg(mk(MODE_BOX, 100, 30, 0, 0, -10, -10, 10, 10));
    send_seg(mk(MODE_BOX, -100, -30, 0, 0, -10, -10, 10, 10));
    send_seg(mk(MODE_BOX, 20, 20, 0, 0, 10, 10, -10, -10));
    send_seg(mk(MODE_BOX, -32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767));
    send_seg(mk(MODE_BOX, 32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768));
    send_seg(mk(MODE_BOX, 1, 32767, 0, -32768, -32768, -32768, 0, 32767));
    drain();

    foreach (radii[k]) begin
      write_radius(radii[k]);
      for (int i = 0; i < 180; i++) begin
        if (k == 2 && i == 0) no_idle = 1'b1;
        if (k == 2 && i == 150) no_idle = 1'b0;
        send_seg(rand_seg());
      end
      if (k == 1) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (400) @(posedge clk);
            hold_off = 1'b0;
          end
          for (int i = 0; i < 120; i++) send_seg(rand_seg());
        join
      end
      drain();
    end

    if (errors == 0) begin
      $display("[arc_endpoint_clipper_unit] OK");
    end else begin
      $display("[arc_endpoint_clipper_unit] ERROR");
    end
    $finish;
  end
endmodule
